// File: design/slrs_pkg.sv
// Shared types, register map, codes and the duty conversion of the servo lid sequencer.
// It depends on nothing. The step logic and the top level both import it.
package slrs_pkg;

    // Angle limit and duty scaling.
    localparam logic [7:0]  ANGLE_MAX       = 8'd180;
    localparam logic [15:0] DUTY_MIN        = 16'd3276;
    localparam int          DUTY_MAX        = 6553;
    localparam int          DUTY_ANGLE_SPAN = 180;
    localparam int          DUTY_SHIFT      = 16;
    // Rounded-up reciprocal of 180 times the duty span, scaled by 2^16.
    // It is exact for every 8-bit angle.
    localparam int          DUTY_RECIP_INT  =
        ((DUTY_MAX - 3276) * (1 << DUTY_SHIFT) + DUTY_ANGLE_SPAN - 1) / DUTY_ANGLE_SPAN;
    localparam logic [20:0] DUTY_RECIP      = 21'(DUTY_RECIP_INT);

    // Register reset values.
    localparam logic [7:0]  CLOSED_RESET = 8'd0;
    localparam logic [7:0]  OPEN_RESET   = 8'd90;
    localparam logic [7:0]  STEP_RESET   = 8'd5;
    localparam logic [15:0] DELAY_RESET  = 16'd20;
    localparam logic [19:0] HOLD_RESET   = 20'(5 * 60 * 1000);

    // Register indexes on the configuration port.
    localparam int          ADDR_W       = 5;
    localparam logic [2:0]  REG_CLOSED   = 3'd0;
    localparam logic [2:0]  REG_OPEN     = 3'd1;
    localparam logic [2:0]  REG_STEP     = 3'd2;
    localparam logic [2:0]  REG_DELAY    = 3'd3;
    localparam logic [2:0]  REG_HOLD     = 3'd4;

    // Input function codes.
    localparam logic [1:0]  FN_TICK      = 2'd0;
    localparam logic [1:0]  FN_NOTIFY    = 2'd1;
    localparam logic [1:0]  FN_MANUAL    = 2'd2;

    // Status codes.
    localparam logic [1:0]  ST_NONE      = 2'd0;
    localparam logic [1:0]  ST_STARTED   = 2'd1;
    localparam logic [1:0]  ST_INVALID   = 2'd2;
    localparam logic [1:0]  ST_LATE      = 2'd3;

    // Phase codes as seen on the result.
    localparam logic [1:0]  PH_IDLE      = 2'd0;
    localparam logic [1:0]  PH_OPENING   = 2'd1;
    localparam logic [1:0]  PH_HOLDING   = 2'd2;
    localparam logic [1:0]  PH_CLOSING   = 2'd3;

    typedef enum logic [3:0] {
        PHS_IDLE    = 4'b0001,
        PHS_OPENING = 4'b0010,
        PHS_HOLDING = 4'b0100,
        PHS_CLOSING = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  closed_angle;
        logic [7:0]  open_angle;
        logic [7:0]  step_size;
        logic [15:0] step_delay_ms;
        logic [19:0] manual_hold_ms;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  angle;
        logic        is_manual;
        logic        manual_pending;
        logic [15:0] step_timer;
        logic [19:0] hold_timer;
    } t_state;

    // Encodes the one-hot phase into the result's phase code.
    function automatic logic [1:0] f_phase_code(t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PHS_IDLE:    code = PH_IDLE;
            PHS_OPENING: code = PH_OPENING;
            PHS_HOLDING: code = PH_HOLDING;
            PHS_CLOSING: code = PH_CLOSING;
            default:     code = PH_IDLE;
        endcase
        return code;
    endfunction

    // Duty for an angle: angle * 3277 / 180 + 3276, by reciprocal multiply.
    function automatic logic [15:0] f_duty(logic [7:0] angle);
        logic [28:0] prod;
        prod = 29'(angle) * 29'(DUTY_RECIP);
        return 16'(prod[28:DUTY_SHIFT]) + DUTY_MIN;
    endfunction

endpackage

// File: design/slrs_step.sv
// Next-state and result logic of the servo lid sequencer for one input beat.
// It depends on slrs_pkg for the state, register and code definitions.
module slrs_step
    import slrs_pkg::*;
(
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_func,
    input  logic [10:0] i_now_minute,
    input  logic        i_window_valid,
    input  logic [10:0] i_window_start,
    input  logic [10:0] i_window_end,
    output t_state      o_state,
    output logic [1:0]  o_status,
    output logic [15:0] o_duty
);

    // Window check: none when usable, else the refusal code.
    function automatic logic [1:0] f_window(logic [10:0] now, logic valid,
                                            logic [10:0] ws, logic [10:0] we);
        logic [11:0] sum;
        logic [10:0] half;
        logic [1:0]  code;
        sum  = 12'(ws) + 12'(we);
        half = sum[11:1];
        if (!valid) begin
            code = ST_INVALID;
        end else if (now >= half || now >= we) begin
            code = ST_LATE;
        end else begin
            code = ST_NONE;
        end
        return code;
    endfunction

    function automatic logic [7:0] f_step_amt(t_cfg c);
        return (c.step_size == 8'd0) ? 8'd1 : c.step_size;
    endfunction

    // One step toward the open angle, clipped there.
    function automatic logic [7:0] f_up(logic [7:0] a, t_cfg c);
        logic [8:0] sum;
        sum = 9'(a) + 9'(f_step_amt(c));
        return (sum > 9'(c.open_angle)) ? c.open_angle : sum[7:0];
    endfunction

    // One step toward the closed angle, clipped there.
    function automatic logic [7:0] f_down(logic [7:0] a, t_cfg c);
        logic [7:0] s;
        logic [7:0] d;
        s = f_step_amt(c);
        d = (a >= s) ? a - s : 8'd0;
        return (d < c.closed_angle) ? c.closed_angle : d;
    endfunction

    function automatic t_state f_hold(t_state s, t_cfg c);
        t_state n;
        n            = s;
        n.phase      = PHS_HOLDING;
        n.step_timer = 16'd0;
        n.hold_timer = s.is_manual ? c.manual_hold_ms : 20'd0;
        return n;
    endfunction

    function automatic t_state f_open(t_state s, logic manual, t_cfg c);
        t_state n;
        n           = s;
        n.is_manual = manual;
        n.angle     = c.closed_angle;
        if (c.closed_angle < c.open_angle) begin
            n.angle      = f_up(c.closed_angle, c);
            n.step_timer = c.step_delay_ms;
            n.phase      = PHS_OPENING;
        end else begin
            n = f_hold(n, c);
        end
        return n;
    endfunction

    // Ends a cycle and starts a latched manual cycle if one waits.
    function automatic t_state f_finish(t_state s, t_cfg c);
        t_state n;
        n            = s;
        n.phase      = PHS_IDLE;
        n.is_manual  = 1'b0;
        n.step_timer = 16'd0;
        n.hold_timer = 20'd0;
        if (s.manual_pending) begin
            n.manual_pending = 1'b0;
            n = f_open(n, 1'b1, c);
        end
        return n;
    endfunction

    function automatic t_state f_close(t_state s, t_cfg c);
        t_state n;
        n            = s;
        n.hold_timer = 20'd0;
        if (s.angle > c.closed_angle) begin
            n.angle      = f_down(s.angle, c);
            n.step_timer = c.step_delay_ms;
            n.phase      = PHS_CLOSING;
        end else begin
            n = f_finish(n, c);
        end
        return n;
    endfunction

    logic [1:0] win_code;
    logic [1:0] fin_status;
    logic [1:0] close_status;
    logic       step_due;

    assign win_code     = f_window(i_now_minute, i_window_valid, i_window_start,
                                   i_window_end);
    assign fin_status   = i_state.manual_pending ? ST_STARTED : ST_NONE;
    assign close_status = (i_state.angle > i_cfg.closed_angle) ? ST_NONE : fin_status;
    assign step_due     = (i_state.step_timer <= 16'd1);

    // Phase sequencing for one beat.
    always_comb begin
        o_state  = i_state;
        o_status = ST_NONE;
        unique case (i_state.phase)
            PHS_IDLE: begin
                if (i_func == FN_NOTIFY) begin
                    if (win_code != ST_NONE) begin
                        o_status = win_code;
                    end else begin
                        o_state  = f_open(i_state, 1'b0, i_cfg);
                        o_status = ST_STARTED;
                    end
                end else if (i_func == FN_MANUAL) begin
                    o_state  = f_open(i_state, 1'b1, i_cfg);
                    o_status = ST_STARTED;
                end
            end
            PHS_OPENING: begin
                if (i_func == FN_TICK) begin
                    if (step_due) begin
                        if (i_state.angle < i_cfg.open_angle) begin
                            o_state.angle      = f_up(i_state.angle, i_cfg);
                            o_state.step_timer = i_cfg.step_delay_ms;
                        end else begin
                            o_state = f_hold(i_state, i_cfg);
                        end
                    end else begin
                        o_state.step_timer = i_state.step_timer - 16'd1;
                    end
                end else if (i_func == FN_MANUAL && !i_state.is_manual) begin
                    o_state.manual_pending = 1'b1;
                end
            end
            PHS_HOLDING: begin
                if (i_func == FN_TICK) begin
                    if (i_state.is_manual) begin
                        if (i_state.hold_timer <= 20'd1) begin
                            o_state  = f_close(i_state, i_cfg);
                            o_status = close_status;
                        end else begin
                            o_state.hold_timer = i_state.hold_timer - 20'd1;
                        end
                    end else if (win_code != ST_NONE) begin
                        o_state  = f_close(i_state, i_cfg);
                        o_status = close_status;
                    end
                end else if (i_func == FN_NOTIFY) begin
                    o_state  = f_close(i_state, i_cfg);
                    o_status = close_status;
                end else if (i_func == FN_MANUAL && !i_state.is_manual) begin
                    o_state.manual_pending = 1'b1;
                end
            end
            PHS_CLOSING: begin
                if (i_func == FN_TICK) begin
                    if (step_due) begin
                        if (i_state.angle > i_cfg.closed_angle) begin
                            o_state.angle      = f_down(i_state.angle, i_cfg);
                            o_state.step_timer = i_cfg.step_delay_ms;
                        end else begin
                            o_state  = f_finish(i_state, i_cfg);
                            o_status = fin_status;
                        end
                    end else begin
                        o_state.step_timer = i_state.step_timer - 16'd1;
                    end
                end else if (i_func == FN_MANUAL && !i_state.is_manual) begin
                    o_state.manual_pending = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    // Duty of the angle after this beat.
    assign o_duty = f_duty(o_state.angle);

endmodule

// File: design/servo_lid_ramp_sequencer_top.sv
// Servo lid ramp sequencer: an accepted input beat reaches the output register as its result
// beat in the next cycle. Throughput is one beat per cycle, set by the single
// registered pass through the step logic; a new beat enters while a result waits only if
// that result is taken in the same cycle, so a stalled result holds off the input.
// Synchronous active-low reset restores the register defaults, the closed idle state and an
// empty output register.
// Depends on slrs_pkg and slrs_step.
module servo_lid_ramp_sequencer_top
    import slrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_func,
    input  logic [10:0]       i_now_minute,
    input  logic              i_window_valid,
    input  logic [10:0]       i_window_start,
    input  logic [10:0]       i_window_end,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_duty,
    output logic              o_drive_enabled,
    output logic [1:0]        o_phase,
    output logic [1:0]        o_status
);

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    logic [1:0]  n_status;
    logic [15:0] n_duty;
    logic        r_out_valid;
    logic [15:0] r_duty;
    logic        r_drive_enabled;
    logic [1:0]  r_phase;
    logic [1:0]  r_status;
    logic        in_fire;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [7:0]  wdata_angle;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign cfg_index  = paddr[ADDR_W-1:2];
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Angle writes saturate at the angle limit.
    assign wdata_angle = (pwdata[7:0] > ANGLE_MAX) ? ANGLE_MAX : pwdata[7:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.closed_angle   <= CLOSED_RESET;
            r_cfg.open_angle     <= OPEN_RESET;
            r_cfg.step_size      <= STEP_RESET;
            r_cfg.step_delay_ms  <= DELAY_RESET;
            r_cfg.manual_hold_ms <= HOLD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_CLOSED: r_cfg.closed_angle   <= wdata_angle;
                REG_OPEN:   r_cfg.open_angle     <= wdata_angle;
                REG_STEP:   r_cfg.step_size      <= pwdata[7:0];
                REG_DELAY:  r_cfg.step_delay_ms  <= pwdata[15:0];
                REG_HOLD:   r_cfg.manual_hold_ms <= pwdata[19:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_index)
            REG_CLOSED: prdata = 32'(r_cfg.closed_angle);
            REG_OPEN:   prdata = 32'(r_cfg.open_angle);
            REG_STEP:   prdata = 32'(r_cfg.step_size);
            REG_DELAY:  prdata = 32'(r_cfg.step_delay_ms);
            REG_HOLD:   prdata = 32'(r_cfg.manual_hold_ms);
            default:    prdata = 32'd0;
        endcase
    end

    // Sequencing logic for the beat on the input ports.
    slrs_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_func         (i_func),
        .i_now_minute   (i_now_minute),
        .i_window_valid (i_window_valid),
        .i_window_start (i_window_start),
        .i_window_end   (i_window_end),
        .o_state        (n_state),
        .o_status       (n_status),
        .o_duty         (n_duty)
    );

    // Sequencer state advances on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PHS_IDLE;
            r_state.angle          <= CLOSED_RESET;
            r_state.is_manual      <= 1'b0;
            r_state.manual_pending <= 1'b0;
            r_state.step_timer     <= 16'd0;
            r_state.hold_timer     <= 20'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_duty          <= n_duty;
            r_drive_enabled <= (n_state.phase != PHS_IDLE);
            r_phase         <= f_phase_code(n_state.phase);
            r_status        <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_duty          = r_duty;
    assign o_drive_enabled = r_drive_enabled;
    assign o_phase         = r_phase;
    assign o_status        = r_status;

    // The lid angle never leaves the servo range.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.angle <= ANGLE_MAX)
        else $error("lid angle above limit");

    // A latched manual request only waits behind a running automatic cycle.
    a_pending_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.manual_pending |-> (!r_state.is_manual && r_state.phase != PHS_IDLE))
        else $error("manual request latched outside an automatic cycle");

    // A started cycle always leaves the block busy.
    a_started_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_STARTED) |-> (r_phase != PH_IDLE && r_drive_enabled))
        else $error("cycle started but phase is idle");

endmodule
